/* rtl/dfd_pkg.sv */
// Shared types, constants and functions for the delimited frame deframer.
// Has no dependencies. Every other file in this folder imports it.
package dfd_pkg;

    localparam int MAX_FRAME_LEN = 256;
    localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);
    localparam int LEN_W         = 9;
    localparam int LEN_MAX       = (1 << LEN_W) - 1;
    localparam int MIN_FRAME     = 6;
    localparam int PROTO_POS     = 4;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_LVL_W       = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] START_BYTE = 8'h78;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;

    localparam logic [7:0] PROTO_LOGIN     = 8'h01;
    localparam logic [7:0] PROTO_HEARTBEAT = 8'h08;
    localparam logic [7:0] PROTO_GPS_ON    = 8'h10;
    localparam logic [7:0] PROTO_GPS_OFF   = 8'h11;
    localparam logic [7:0] PROTO_DETAILS   = 8'h13;
    localparam logic [7:0] PROTO_LBS_A     = 8'h17;
    localparam logic [7:0] PROTO_LBS_B     = 8'h18;
    localparam logic [7:0] PROTO_LBS_C     = 8'h19;
    localparam logic [7:0] PROTO_TIME_SYNC = 8'h30;

    typedef enum logic [3:0] {
        KIND_LOGIN     = 4'd0,
        KIND_HEARTBEAT = 4'd1,
        KIND_GPS_ON    = 4'd2,
        KIND_GPS_OFF   = 4'd3,
        KIND_DETAILS   = 4'd4,
        KIND_LBS       = 4'd5,
        KIND_TIME_SYNC = 4'd6,
        KIND_UNKNOWN   = 4'd7,
        KIND_OVERFLOW  = 4'd8
    } t_kind;

    // One finished frame as handed from the parser to the result stage.
    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [7:0]       proto;
        logic             ovf;
    } t_rec;

    function automatic t_kind classify(logic [7:0] proto);
        t_kind k;
        k = KIND_UNKNOWN;
        unique case (proto)
            PROTO_LOGIN:     k = KIND_LOGIN;
            PROTO_HEARTBEAT: k = KIND_HEARTBEAT;
            PROTO_GPS_ON:    k = KIND_GPS_ON;
            PROTO_GPS_OFF:   k = KIND_GPS_OFF;
            PROTO_DETAILS:   k = KIND_DETAILS;
            PROTO_LBS_A,
            PROTO_LBS_B,
            PROTO_LBS_C:     k = KIND_LBS;
            PROTO_TIME_SYNC: k = KIND_TIME_SYNC;
            default:         k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(logic [CNT_W-1:0] c);
        logic [LEN_W-1:0] l;
        if (32'(c) > 32'(LEN_MAX)) begin
            l = '1;
        end else begin
            l = LEN_W'(c);
        end
        return l;
    endfunction

endpackage

/* rtl/dfd_parser.sv */
// Front end: hunts for the header, counts frame bytes and spots the terminator.
// Pushes a record per non-runt closed or overflowed frame. Depends on dfd_pkg.
module dfd_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output dfd_pkg::t_rec o_rec
);
    import dfd_pkg::*;

    logic             r_inside, n_inside;
    logic             r_last_start, n_last_start;
    logic             r_last_cr, n_last_cr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_proto, n_proto;
    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       proto_inc;

    assign cnt_inc   = r_count + CNT_W'(1);
    assign proto_inc = (cnt_inc == CNT_W'(PROTO_POS)) ? i_byte : r_proto;

    always_comb begin
        n_inside     = r_inside;
        n_last_start = r_last_start;
        n_last_cr    = r_last_cr;
        n_count      = r_count;
        n_proto      = r_proto;
        o_push       = 1'b0;
        o_rec.len    = cnt_inc;
        o_rec.proto  = proto_inc;
        o_rec.ovf    = 1'b0;
        if (i_valid) begin
            if (!r_inside) begin
                if (i_byte == START_BYTE && r_last_start) begin
                    n_inside     = 1'b1;
                    n_last_start = 1'b0;
                    n_last_cr    = 1'b0;
                    n_count      = CNT_W'(2);
                    n_proto      = '0;
                end else begin
                    n_last_start = (i_byte == START_BYTE);
                end
            end else begin
                n_count = cnt_inc;
                n_proto = proto_inc;
                priority if (i_byte == LF_BYTE && r_last_cr) begin
                    // close; drop runts
                    o_push   = (32'(cnt_inc) >= MIN_FRAME);
                    n_inside = 1'b0;
                end else if (32'(cnt_inc) >= MAX_FRAME_LEN) begin
                    // abandon at the length limit
                    o_push    = 1'b1;
                    o_rec.len = CNT_W'(MAX_FRAME_LEN);
                    o_rec.ovf = 1'b1;
                    n_inside  = 1'b0;
                end else begin
                    n_last_cr = (i_byte == CR_BYTE);
                end
                if (!n_inside) begin
                    n_last_start = 1'b0;
                    n_last_cr    = 1'b0;
                    n_count      = '0;
                    n_proto      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b0;
            r_last_start <= 1'b0;
            r_last_cr    <= 1'b0;
            r_count      <= '0;
            r_proto      <= '0;
        end else begin
            r_inside     <= n_inside;
            r_last_start <= n_last_start;
            r_last_cr    <= n_last_cr;
            r_count      <= n_count;
            r_proto      <= n_proto;
        end
    end

    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside |-> (r_count >= CNT_W'(2)) && (32'(r_count) < MAX_FRAME_LEN))
        else $error("frame byte count out of range");

    a_count_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside |-> (r_count == '0) && !r_last_cr)
        else $error("frame state left over while hunting");

endmodule

/* rtl/dfd_queue.sv */
// Short record queue between parser and result stage.
// Register array with combinational read. Depends on dfd_pkg.
module dfd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dfd_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output dfd_pkg::t_rec o_rec
);
    import dfd_pkg::*;

    t_rec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_LVL_W-1:0] r_level, n_level;
    logic               do_push, do_pop;

    assign o_full  = (r_level == Q_LVL_W'(Q_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = do_push ? Q_PTR_W'(32'(r_wr) + 1 == Q_DEPTH ? 0 : 32'(r_wr) + 1) : r_wr;
        n_rd    = do_pop  ? Q_PTR_W'(32'(r_rd) + 1 == Q_DEPTH ? 0 : 32'(r_rd) + 1) : r_rd;
        n_level = r_level + Q_LVL_W'(do_push) - Q_LVL_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_level) <= Q_DEPTH)
        else $error("queue level beyond depth");

endmodule

/* rtl/dfd_result.sv */
// Back end: classifies queued records and holds the presented result.
// Output register with pop handshake. Depends on dfd_pkg.
module dfd_result (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  dfd_pkg::t_rec             i_rec,
    output logic                      o_q_pop,
    input  logic                      i_pop,
    output logic                      o_valid,
    output logic [dfd_pkg::LEN_W-1:0] o_len,
    output logic [7:0]                o_proto,
    output logic [3:0]                o_kind
);
    import dfd_pkg::*;

    logic             r_valid, n_valid;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_proto;
    t_kind            r_kind;
    logic             load;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load;
    assign n_valid = load || (r_valid && !i_pop);
    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_proto = r_proto;
    assign o_kind  = r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_len   <= sat_len(i_rec.len);
            r_proto <= i_rec.proto;
            r_kind  <= i_rec.ovf ? KIND_OVERFLOW : classify(i_rec.proto);
        end
    end

    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_kind == KIND_OVERFLOW) |-> r_len == sat_len(CNT_W'(MAX_FRAME_LEN)))
        else $error("overflow result with wrong length");

    a_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_kind != KIND_OVERFLOW) |-> 32'(r_len) >= MIN_FRAME)
        else $error("short frame reached the result port");

endmodule

/* rtl/delimited_frame_deframer.sv */
// Top level of the delimited frame deframer: parser, record queue, result stage.
// Depends on dfd_pkg, dfd_parser, dfd_queue and dfd_result.
//
// Takes one stream byte per cycle on push/full and gives one result per finished
// frame on empty/pop: frame length, protocol number (fourth frame byte) and class.
// A frame opens on two consecutive 0x78 bytes and closes on 0x0D 0x0A; frames
// under six bytes are dropped, and a frame reaching MAX_FRAME_LEN bytes unclosed
// gives an overflow result. Each byte is parsed in the cycle it is taken, so the
// block sustains one byte per cycle while full is low; results pass through a
// four-record queue and an output register, and full rises only when the queue
// is full, which needs four unread results behind the one on the result ports.
module delimited_frame_deframer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                i_data_byte,
    output logic                      empty,
    input  logic                      pop,
    output logic [dfd_pkg::LEN_W-1:0] o_frame_length,
    output logic [7:0]                o_protocol_number,
    output logic [3:0]                o_frame_kind
);
    import dfd_pkg::*;

    logic in_xfer;
    logic rec_push;
    t_rec rec_in;
    t_rec rec_out;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic res_valid;

    assign full    = q_full;
    assign empty   = !res_valid;
    assign in_xfer = push && !q_full;

    dfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer),
        .i_byte  (i_data_byte),
        .o_push  (rec_push),
        .o_rec   (rec_in)
    );

    dfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rec   (rec_out)
    );

    dfd_result u_result (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_rec     (rec_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_valid   (res_valid),
        .o_len     (o_frame_length),
        .o_proto   (o_protocol_number),
        .o_kind    (o_frame_kind)
    );

endmodule
